### design/scl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_pkg
// Types and constants shared by the serial command loader modules.
// ----------------------------------------------------------------------------
package scl_pkg;

    typedef enum logic [1:0] {
        MODE_SCAN = 2'd0,
        MODE_SIZE = 2'd1,
        MODE_DATA = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        EV_PONG  = 3'd0,
        EV_START = 3'd1,
        EV_SIZE  = 3'd2,
        EV_WRITE = 3'd3,
        EV_DONE  = 3'd4
    } t_event;

    // One queue entry: a result, optionally followed by a load_complete beat.
    typedef struct packed {
        t_event      ev;
        logic [31:0] addr;
        logic [7:0]  data;
        logic        with_done;
    } t_entry;

    localparam logic [31:0] CMD_PING      = 32'h5049_4E47;  // "PING"
    localparam logic [31:0] CMD_LOAD      = 32'h4C4F_4144;  // "LOAD"
    localparam logic [31:0] BASE_AT_RESET = 32'h8001_0000;

    localparam int OUT_TDATA_W = 48;

endpackage

### design/scl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_front
// Byte parser: command scan, size gathering and payload addressing.
// ----------------------------------------------------------------------------
module scl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_rx_byte,
    input  logic [31:0]     i_load_base,
    output logic            o_push,
    output scl_pkg::t_entry o_entry
);
    import scl_pkg::*;

    t_mode       r_mode,   n_mode;
    logic [23:0] r_window, n_window;
    logic [1:0]  r_cnt,    n_cnt;
    logic [23:0] r_size,   n_size;
    logic [31:0] r_index,  n_index;
    logic [31:0] r_remain, n_remain;

    logic [31:0] w_seq;
    logic [31:0] w_full_size;

    assign w_seq       = {r_window, i_rx_byte};
    assign w_full_size = {i_rx_byte, r_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SCAN;
            r_window <= '0;
            r_cnt    <= '0;
            r_size   <= '0;
            r_index  <= '0;
            r_remain <= '0;
        end else begin
            r_mode   <= n_mode;
            r_window <= n_window;
            r_cnt    <= n_cnt;
            r_size   <= n_size;
            r_index  <= n_index;
            r_remain <= n_remain;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_window = r_window;
        n_cnt    = r_cnt;
        n_size   = r_size;
        n_index  = r_index;
        n_remain = r_remain;
        o_push   = 1'b0;
        o_entry  = '{ev: EV_PONG, addr: '0, data: '0, with_done: 1'b0};
        if (i_accept) begin
            unique case (r_mode)
                MODE_SIZE: begin
                    n_cnt = r_cnt + 2'd1;
                    unique case (r_cnt)
                        2'd0: n_size[7:0]   = i_rx_byte;
                        2'd1: n_size[15:8]  = i_rx_byte;
                        2'd2: n_size[23:16] = i_rx_byte;
                        default: begin
                            o_push   = 1'b1;
                            o_entry.ev = EV_SIZE;
                            if (w_full_size == '0) begin
                                o_entry.with_done = 1'b1;
                                n_mode   = MODE_SCAN;
                                n_window = '0;
                            end else begin
                                n_mode   = MODE_DATA;
                                n_index  = '0;
                                n_remain = w_full_size;
                            end
                        end
                    endcase
                end
                MODE_DATA: begin
                    o_push       = 1'b1;
                    o_entry.ev   = EV_WRITE;
                    o_entry.addr = i_load_base + r_index;
                    o_entry.data = i_rx_byte;
                    n_index      = r_index + 32'd1;
                    n_remain     = r_remain - 32'd1;
                    if (r_remain == 32'd1) begin
                        o_entry.with_done = 1'b1;
                        n_mode   = MODE_SCAN;
                        n_window = '0;
                        n_cnt    = '0;
                    end
                end
                default: begin
                    // scanning; the unused mode code behaves the same
                    n_window = w_seq[23:0];
                    n_mode   = MODE_SCAN;
                    if (w_seq == CMD_PING) begin
                        o_push     = 1'b1;
                        o_entry.ev = EV_PONG;
                    end else if (w_seq == CMD_LOAD) begin
                        o_push     = 1'b1;
                        o_entry.ev = EV_START;
                        n_mode     = MODE_SIZE;
                        n_cnt      = '0;
                        n_size     = '0;
                        n_index    = '0;
                    end
                end
            endcase
        end
    end

endmodule

### design/scl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_queue
// Small register FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module scl_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scl_pkg::t_entry i_entry,
    input  logic            i_pop,
    output scl_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);
    import scl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### design/scl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_back
// Output stage: turns queue entries into one or two result beats.
// ----------------------------------------------------------------------------
module scl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scl_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [scl_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic            o_tlast
);
    import scl_pkg::*;

    logic        r_valid;
    logic        r_pend_done;
    t_event      r_ev;
    logic [31:0] r_addr;
    logic [7:0]  r_data;
    logic        r_last;
    logic        w_free;

    assign w_free = !r_valid || i_tready;
    assign o_pop  = w_free && !r_pend_done && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_pend_done <= 1'b0;
        end else if (w_free) begin
            if (r_pend_done) begin
                r_valid     <= 1'b1;
                r_pend_done <= 1'b0;
            end else begin
                r_valid     <= !i_empty;
                r_pend_done <= !i_empty && i_entry.with_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_pend_done) begin
                r_ev   <= EV_DONE;
                r_addr <= '0;
                r_data <= '0;
                r_last <= 1'b1;
            end else begin
                r_ev   <= i_entry.ev;
                r_addr <= i_entry.addr;
                r_data <= i_entry.data;
                r_last <= !i_entry.with_done;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tlast  = r_last;
    assign o_tdata  = {5'd0, r_data, r_addr, r_ev};

endmodule

### design/serial_command_loader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_loader
// Scans received bytes for PING and LOAD and reports loader events.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the slave stream. The parser decides
// each byte in the cycle it arrives and puts its results into a QUEUE_DEPTH
// entry queue; the output stage sends one beat per cycle, so a byte that
// causes two results (the last payload byte, or a zero size) takes two output
// beats. Two such bytes are always at least eight bytes apart, so the queue
// drains the extra beat on its own; input stalls only when the queue is full,
// which happens only when the output side is held off. The user must write
// load_base via i_cfg_we / i_cfg_wdata only while idle; the block won't check.
module serial_command_loader #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] event_res, [34:3] write_address, [42:35] write_data, [47:43] zero
    output logic [scl_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast     // last
);
    import scl_pkg::*;

    logic [31:0] r_load_base;
    logic        w_accept;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    t_entry      w_push_entry;
    t_entry      w_head_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_base <= BASE_AT_RESET;
        end else if (i_cfg_we) begin
            r_load_base <= i_cfg_wdata;
        end
    end

    assign o_s_axis_tready = !w_full;
    assign w_accept        = i_s_axis_tvalid && !w_full;

    scl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_s_axis_tdata),
        .i_load_base (r_load_base),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    scl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    scl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (w_head_entry),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
